FILE: hw/rtl/csm_pkg.sv
package csm_pkg;

  localparam int COL_W  = 10;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 64;
  localparam int ROW_W  = 16;
  localparam int FRAC_W = 16;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_LOAD    = 2'd0;
  localparam func_t FUNC_NONZERO = 2'd1;
  localparam func_t FUNC_EMPTY   = 2'd2;
  localparam func_t FUNC_RESTART = 2'd3;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ACC_W-1:0] acc_t;

endpackage

FILE: hw/rtl/csm_ram.sv
module csm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/csr_sparse_matvec_rows.sv
// Path: the transaction that closes a row passes the s1, s2 and s3 registers
// before its row result reaches the output register.
// Throughput: one input transaction per cycle; the whole pipeline holds only
// while a finished result waits on a stalled output.
// Reset (rst_n, synchronous): clears the pipeline valids, the accumulator and
// the row counter. The vector store is not cleared and is undefined until written.
module csr_sparse_matvec_rows
  import csm_pkg::*;
#(
  parameter int VEC_DEPTH = 1024,
  parameter int MAX_ROWS  = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  func_t            in_func,
  input  logic [COL_W-1:0] in_col,
  input  val_t             in_value,
  input  logic             in_row_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] out_row_index,
  output val_t             out_row_value,
  output logic             out_saturated
);

  localparam int AW  = $clog2(VEC_DEPTH);
  localparam int XW  = 17;

  logic          advance;
  logic          accept;
  logic [XW-1:0] col_ext;
  logic          col_ok;
  logic [AW-1:0] ram_addr;
  val_t          ram_rdata;

  logic          s1_vld_r;
  func_t         s1_func_r;
  logic          s1_ok_r;
  val_t          s1_value_r;
  logic          s1_end_r;

  logic          s2_vld_r;
  func_t         s2_func_r;
  logic          s2_end_r;
  acc_t          s2_prod_r;
  val_t          s1_vec;

  logic          s3_vld_r;
  acc_t          s3_sum_r;
  logic [ROW_W-1:0] s3_row_r;

  acc_t          acc_r;
  acc_t          acc_nxt;
  acc_t          acc_sum;
  logic [ROW_W-1:0] cnt_r;
  logic [ROW_W-1:0] cnt_nxt;
  logic [XW-1:0] cnt_inc;
  logic          emit;
  acc_t          emit_sum;

  logic          out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  val_t          out_value_r;
  logic          out_sat_r;
  logic          sat_pos;
  logic          sat_neg;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  assign col_ext  = XW'(in_col);
  assign col_ok   = col_ext < XW'(VEC_DEPTH);
  assign ram_addr = col_ext[AW-1:0];

  csm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(VEC_DEPTH)
  ) u_vec_ram (
    .clk  (clk),
    .we   (accept && (in_func == FUNC_LOAD) && col_ok),
    .waddr(ram_addr),
    .wdata(in_value),
    .re   (advance),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  assign s1_vec = s1_ok_r ? ram_rdata : '0;

  always_comb begin
    acc_sum  = acc_r + s2_prod_r;
    acc_nxt  = acc_r;
    emit     = 1'b0;
    emit_sum = acc_sum;
    cnt_inc  = XW'(cnt_r) + XW'(1);
    cnt_nxt  = cnt_r;
    if (s2_vld_r) begin
      case (s2_func_r)
        FUNC_NONZERO: begin
          acc_nxt = acc_sum;
          if (s2_end_r) begin
            emit    = 1'b1;
            acc_nxt = '0;
          end
        end
        FUNC_EMPTY: begin
          emit     = 1'b1;
          emit_sum = '0;
          acc_nxt  = '0;
        end
        FUNC_RESTART: begin
          acc_nxt = '0;
          cnt_nxt = '0;
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      if (emit) begin
        cnt_nxt = (cnt_inc == XW'(MAX_ROWS)) ? '0 : cnt_inc[ROW_W-1:0];
      end
    end
  end

  assign sat_pos = !s3_sum_r[ACC_W-1] && (s3_sum_r[ACC_W-2:FRAC_W+VAL_W-1] != '0);
  assign sat_neg = s3_sum_r[ACC_W-1] && (s3_sum_r[ACC_W-2:FRAC_W+VAL_W-1] != '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
    end else if (advance) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= emit;
      out_valid_r <= s3_vld_r;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_func_r  <= in_func;
      s1_ok_r    <= col_ok;
      s1_value_r <= in_value;
      s1_end_r   <= in_row_end;
      s2_func_r  <= s1_func_r;
      s2_end_r   <= s1_end_r;
      s2_prod_r  <= ACC_W'(s1_value_r) * ACC_W'(s1_vec);
      s3_sum_r   <= emit_sum;
      s3_row_r   <= cnt_r;
      out_row_r  <= s3_row_r;
      out_sat_r  <= sat_pos || sat_neg;
      if (sat_pos) begin
        out_value_r <= {1'b0, {(VAL_W-1){1'b1}}};
      end else if (sat_neg) begin
        out_value_r <= {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
        out_value_r <= s3_sum_r[FRAC_W+VAL_W-1:FRAC_W];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_row_value = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

FILE: hw/rtl/csm_checker.sv
module csm_checker
  import csm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ROW_W-1:0] out_row_index,
  input val_t             out_row_value,
  input logic             out_saturated
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_index) &&
      $stable(out_row_value) && $stable(out_saturated))
    else $error("stalled result changed");

  // A clipped sum shows one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_row_value == 32'sh7FFFFFFF) || (out_row_value == 32'sh80000000))
    else $error("saturated flag without limit value");

  // The input side is held off only by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Reset empties the pipeline.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind csr_sparse_matvec_rows csm_checker u_csm_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import csm_pkg::*;

  localparam int PIPE_LAT     = 3;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 1020;

  typedef struct packed {
    logic [ROW_W-1:0] index;
    val_t             value;
    logic             sat;
  } row_result_t;

  class row_sum_scoreboard;
    localparam acc_t SUM_MAX = 64'sd2147483647;
    localparam acc_t SUM_MIN = -64'sd2147483648;

    val_t             vec_mem [1024];
    acc_t             acc;
    logic [ROW_W-1:0] row_cnt;
    row_result_t      expected_rows [$];
    int               errors;

    function new();
      acc     = '0;
      row_cnt = '0;
      errors  = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t ERROR %s", $time, msg);
    endfunction

    function void close_row(acc_t sum);
      acc_t        shifted;
      row_result_t r;
      shifted = sum >>> FRAC_W;
      r.index = row_cnt;
      r.sat   = 1'b0;
      if (shifted > SUM_MAX) begin
        r.value = 32'h7FFFFFFF;
        r.sat   = 1'b1;
      end else if (shifted < SUM_MIN) begin
        r.value = 32'h80000000;
        r.sat   = 1'b1;
      end else begin
        r.value = shifted[VAL_W-1:0];
      end
      expected_rows.push_back(r);
      row_cnt = row_cnt + 1'b1;
      acc     = '0;
    endfunction

    function void note_input(func_t f, logic [COL_W-1:0] c, val_t v, logic re);
      acc_t a;
      acc_t b;
      case (f)
        FUNC_LOAD: vec_mem[c] = v;
        FUNC_NONZERO: begin
          a   = ACC_W'(v);
          b   = ACC_W'(vec_mem[c]);
          acc = acc + a * b;
          if (re) close_row(acc);
        end
        FUNC_EMPTY: close_row('0);
        FUNC_RESTART: begin
          row_cnt = '0;
          acc     = '0;
        end
      endcase
    endfunction

    function void check_result(logic [ROW_W-1:0] idx, val_t val, logic sat);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        flag($sformatf("unexpected row result: index %0d value %h sat %0b", idx, val, sat));
        return;
      end
      want = expected_rows.pop_front();
      if (idx !== want.index || val !== want.value || sat !== want.sat)
        flag($sformatf("row mismatch: expected index %0d value %h sat %0b, got %0d %h %0b",
                       want.index, want.value, want.sat, idx, val, sat));
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  func_t            in_func       = FUNC_LOAD;
  logic [COL_W-1:0] in_col        = '0;
  val_t             in_value      = '0;
  logic             in_row_end    = 1'b0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [ROW_W-1:0] out_row_index;
  val_t             out_row_value;
  logic             out_saturated;

  row_sum_scoreboard sb;
  bit                loaded [1024];
  logic [COL_W-1:0]  loaded_cols [$];
  bit                burst_mode = 1'b0;
  bit                hold_req   = 1'b0;
  int                sent_items = 0;

  csr_sparse_matvec_rows uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_col        (in_col),
    .in_value      (in_value),
    .in_row_end    (in_row_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_row_value (out_row_value),
    .out_saturated (out_saturated)
  );

  always #5 clk = ~clk;

  task automatic send_item(func_t f, logic [COL_W-1:0] c, val_t v, logic re);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_func    <= f;
    in_col     <= c;
    in_value   <= v;
    in_row_end <= re;
    do @(posedge clk); while (in_stall);
    sb.note_input(f, c, v, re);
    sent_items++;
  endtask

  task automatic load_entry(logic [COL_W-1:0] c, val_t v);
    if (!loaded[c]) begin
      loaded[c] = 1'b1;
      loaded_cols.push_back(c);
    end
    send_item(FUNC_LOAD, c, v, 1'($urandom));
  endtask

  function automatic logic [COL_W-1:0] pick_col();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  function automatic val_t rand_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h00000000;
          3: return 32'hFFFFFFFF;
          default: return 32'h00010000;
        endcase
      end
      default: return $urandom_range(0, 32'h1FFFFF) - 32'h100000;
    endcase
  endfunction

  task automatic send_row(int n);
    for (int i = 0; i < n; i++)
      send_item(FUNC_NONZERO, pick_col(), rand_value(), i == n - 1);
  endtask

  task automatic send_empty();
    send_item(FUNC_EMPTY, COL_W'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic send_restart();
    send_item(FUNC_RESTART, COL_W'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (burst_mode) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 11);
      end
      repeat (gap) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_row_index, out_row_value, out_saturated);
    end
  end

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    int target;
    int next_mode;
    int pick;
    bit pressed;
    bit paused;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_restart();
    load_entry(10'd0, 32'h00010000);
    load_entry(10'h3FF, 32'h80000000);
    load_entry(10'd1, 32'h7FFFFFFF);
    load_entry(10'd2, 32'hFFFF0000);
    load_entry(10'd3, 32'h00000001);
    send_item(FUNC_NONZERO, 10'd0, 32'h00028000, 1'b1);
    send_empty();
    // Four products of 2^62 wrap the accumulator back to zero.
    repeat (3) send_item(FUNC_NONZERO, 10'h3FF, 32'h80000000, 1'b0);
    send_item(FUNC_NONZERO, 10'h3FF, 32'h80000000, 1'b1);
    send_item(FUNC_NONZERO, 10'h3FF, 32'h80000000, 1'b1);
    send_item(FUNC_NONZERO, 10'd1, 32'h80000000, 1'b1);
    send_item(FUNC_NONZERO, 10'd3, 32'hFFFFFFFF, 1'b1);
    send_item(FUNC_NONZERO, 10'd2, 32'h7FFFFFFF, 1'b1);
    send_item(FUNC_NONZERO, 10'd0, 32'h00010000, 1'b0);
    send_empty();
    send_item(FUNC_NONZERO, 10'd0, 32'h00030000, 1'b0);
    send_restart();
    send_item(FUNC_NONZERO, 10'd2, 32'h00020000, 1'b1);
    wait_drain();

    target    = sent_items + RANDOM_ITEMS;
    next_mode = sent_items;
    pressed   = 1'b0;
    paused    = 1'b0;
    while (sent_items < target) begin
      if (sent_items >= next_mode) begin
        burst_mode = ($urandom_range(0, 3) == 0);
        next_mode  = sent_items + 40;
      end
      if (!pressed && sent_items >= target - 700) begin
        pressed    = 1'b1;
        burst_mode = 1'b1;
        hold_req   = 1'b1;
        repeat (40) send_row(1);
        burst_mode = 1'b0;
      end else if (!paused && sent_items >= target - 350) begin
        paused = 1'b1;
        wait_drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        load_entry(COL_W'($urandom), rand_value());
      end else if (pick < 80) begin
        send_row($urandom_range(1, 6));
      end else if (pick < 88) begin
        send_empty();
      end else if (pick < 91) begin
        send_restart();
      end else if (pick < 96) begin
        send_item(FUNC_NONZERO, pick_col(), rand_value(), 1'b0);
      end else begin
        send_item(FUNC_NONZERO, pick_col(), rand_value(), 1'b0);
        send_empty();
      end
    end
    wait_drain();

    send_row(2);
    send_empty();
    wait_drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
